[sv/h1511_pkg.sv]
// package for the hamming(15,11) stream decoder
// holds state and result structs shared by the step logic and the top level
// no dependencies
package h1511_pkg;

  localparam int unsigned CodeLen = 15;
  localparam int unsigned DataLen = 11;

  typedef struct packed {
    logic [13:0] code_bits;
    logic [3:0]  code_cnt;
    logic [6:0]  data_bits;
    logic [2:0]  data_cnt;
    logic [31:0] corr_cnt;
  } h1511_state_t;

  typedef struct packed {
    logic [7:0]  byte0;
    logic [7:0]  byte1;
    logic [1:0]  nres;
    logic [31:0] total;
  } h1511_res_t;

endpackage

[sv/h1511_step.sv]
// one-byte step of the hamming(15,11) stream decoder: append coded bits,
// decode and correct a full codeword, repack data bits into bytes
// depends on h1511_pkg
module h1511_step (
  input  h1511_pkg::h1511_state_t state_i,
  input  logic [7:0]              byte_i,
  output h1511_pkg::h1511_state_t state_o,
  output h1511_pkg::h1511_res_t   res_o
);
  import h1511_pkg::*;

  logic [21:0] code_cat;
  logic [4:0]  code_cnt8;
  logic [14:0] word;
  logic [3:0]  syn;
  logic [15:0] pos;
  logic [10:0] dword;
  logic        data_fix;
  logic [17:0] data_cat;
  logic [4:0]  data_cnt;
  logic [31:0] corr_next;

  always_comb begin
    code_cat  = {8'b0, state_i.code_bits} | ({14'b0, byte_i} << state_i.code_cnt);
    code_cnt8 = {1'b0, state_i.code_cnt} + 5'd8;
    word      = code_cat[14:0];
    syn       = 4'd0;
    for (int k = 0; k < CodeLen; k++) begin
      if (word[k]) begin
        syn = syn ^ 4'(k + 1);
      end
    end
    pos = {word, 1'b0};
    if (syn != 4'd0) begin
      pos[syn] = ~pos[syn];
    end
    dword    = {pos[15:9], pos[7:5], pos[3]};
    data_fix = (syn != 4'd0) && ((syn & (syn - 4'd1)) != 4'd0);

    state_o   = state_i;
    corr_next = state_i.corr_cnt;
    if (code_cnt8 >= 5'(CodeLen)) begin
      state_o.code_bits = {7'b0, code_cat[21:15]};
      state_o.code_cnt  = 4'(code_cnt8 - 5'(CodeLen));
      data_cat = {11'b0, state_i.data_bits} | ({7'b0, dword} << state_i.data_cnt);
      data_cnt = {2'b0, state_i.data_cnt} + 5'(DataLen);
      if (data_fix && (state_i.corr_cnt != 32'hFFFF_FFFF)) begin
        corr_next = state_i.corr_cnt + 32'd1;
      end
    end else begin
      state_o.code_bits = code_cat[13:0];
      state_o.code_cnt  = code_cnt8[3:0];
      data_cat = {11'b0, state_i.data_bits};
      data_cnt = {2'b0, state_i.data_cnt};
    end
    state_o.corr_cnt = corr_next;

    res_o.byte0 = data_cat[7:0];
    res_o.byte1 = data_cat[15:8];
    res_o.total = corr_next;
    if (data_cnt >= 5'd16) begin
      res_o.nres        = 2'd2;
      state_o.data_bits = {5'b0, data_cat[17:16]};
      state_o.data_cnt  = 3'(data_cnt - 5'd16);
    end else if (data_cnt >= 5'd8) begin
      res_o.nres        = 2'd1;
      state_o.data_bits = data_cat[14:8];
      state_o.data_cnt  = 3'(data_cnt - 5'd8);
    end else begin
      res_o.nres        = 2'd0;
      state_o.data_bits = data_cat[6:0];
      state_o.data_cnt  = data_cnt[2:0];
    end
  end

endmodule

[sv/hamming_15_11_stream_decoder_core.sv]
// hamming(15,11) stream decoder top level: input register, step logic,
// two-entry result queue and output beat sequencing
// depends on h1511_pkg and h1511_step
// path: an accepted byte is held in the input register, its results in the queue
// flow: a new input beat is taken only while queue and input register together
// hold at most one entry; a two-byte result leaves as two beats, one byte each
// reset: asynchronous active low, clears decoder state, counter and queue
module hamming_15_11_stream_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // in_byte[7:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // out_byte[7:0], error_total[39:8]
  output logic        m_axis_tlast
);
  import h1511_pkg::*;

  logic         in_valid_q;
  logic [7:0]   in_byte_q;
  h1511_state_t state_q, state_d;
  h1511_res_t   res;
  h1511_res_t   fifo_q [2];
  logic         wr_ptr_q, rd_ptr_q;
  logic [1:0]   count_q;
  logic         sel_q;
  logic         push, pop, beat_out;
  h1511_res_t   head;

  h1511_step u_step (
    .state_i (state_q),
    .byte_i  (in_byte_q),
    .state_o (state_d),
    .res_o   (res)
  );

  assign s_axis_tready = (2'(count_q + {1'b0, in_valid_q}) <= 2'd1);
  assign head          = fifo_q[rd_ptr_q];
  assign m_axis_tvalid = (count_q != 2'd0);
  assign m_axis_tdata  = {head.total, (sel_q ? head.byte1 : head.byte0)};
  assign m_axis_tlast  = (head.nres == 2'd1) || sel_q;
  assign beat_out      = m_axis_tvalid && m_axis_tready;
  assign pop           = beat_out && m_axis_tlast;
  assign push          = in_valid_q && (res.nres != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      state_q    <= '0;
      wr_ptr_q   <= 1'b0;
      rd_ptr_q   <= 1'b0;
      count_q    <= 2'd0;
      sel_q      <= 1'b0;
    end else begin
      in_valid_q <= s_axis_tvalid && s_axis_tready;
      if (in_valid_q) begin
        state_q <= state_d;
      end
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
        sel_q    <= 1'b0;
      end else if (beat_out) begin
        sel_q <= 1'b1;
      end
      count_q <= 2'(count_q + {1'b0, push} - {1'b0, pop});
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
    if (push) begin
      fifo_q[wr_ptr_q] <= res;
    end
  end

endmodule
